FILE: rtl/msog_pkg.sv
// Shared types, register codes and size limits for the matrix scan order generator.
// Used by msog_walk, matrix_scan_order_generator and msog_checker; depends on nothing.
package msog_pkg;

	// Largest matrix accepted without a size error.
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;

	// Widths of the configuration registers and the result fields.
	localparam int DimW   = 5;
	localparam int ModeW  = 3;
	localparam int IdxW   = 4;
	localparam int SeqW   = 9;
	localparam int CfgW   = 5;
	localparam int CfgIdW = 2;

	// Size limits widened so that they can be compared with a register value.
	localparam logic [DimW+1:0] MaxRowsW = (DimW + 2)'(MAX_ROWS);
	localparam logic [DimW+1:0] MaxColsW = (DimW + 2)'(MAX_COLS);

	// Configuration register indexes.
	typedef enum logic [CfgIdW-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_SCAN_MODE = 2'd2
	} cfg_reg_t;

	// Scan orders; codes above the column snake behave as a raster.
	typedef enum logic [ModeW-1:0] {
		MODE_RASTER    = 3'd0,
		MODE_DIAG_DR   = 3'd1,
		MODE_DIAG_UL   = 3'd2,
		MODE_ROW_SNAKE = 3'd3,
		MODE_COL_SNAKE = 3'd4
	} scan_mode_t;

	// Position of the walker between transactions.
	typedef struct packed {
		logic [DimW-1:0] row;
		logic [DimW-1:0] col;
		logic [SeqW-1:0] count;
		logic [DimW-1:0] diag;
		logic            second;
		logic            active;
	} walk_state_t;

	// One result transaction.
	typedef struct packed {
		logic [IdxW-1:0] row_index;
		logic [IdxW-1:0] col_index;
		logic [SeqW-1:0] seq_value;
		logic            last_cell;
		logic            size_error;
	} walk_result_t;

endpackage

FILE: rtl/matrix_scan_order_generator.sv
// Output: each result is registered in the output register, or in the skid stage
// while that is stalled. Throughput: one cell per clock cycle while out_stall is low;
// the walk step is combinational, and a two-entry output register lets a transaction
// in while a result is stalled. Reset: arst_n clears the walker to idle, the result
// stages to empty and the registers to a 1 x 1 raster scan.
module matrix_scan_order_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [msog_pkg::CfgIdW-1:0]   cfg_index,
	input  logic [msog_pkg::CfgW-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [msog_pkg::IdxW-1:0]     row_index,
	output logic [msog_pkg::IdxW-1:0]     col_index,
	output logic [msog_pkg::SeqW-1:0]     seq_value,
	output logic                          last_cell,
	output logic                          size_error
);
	import msog_pkg::*;

	logic [DimW-1:0]  row_count_q;
	logic [DimW-1:0]  col_count_q;
	logic [ModeW-1:0] scan_mode_q;
	walk_state_t      state_q;
	walk_state_t      next_state;
	walk_result_t     step_result;
	walk_result_t     main_q;
	walk_result_t     skid_q;
	logic             main_valid_q;
	logic             skid_valid_q;
	logic             in_fire;
	logic             out_free;

	// Configuration registers; a write to any of them sends the walker idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DimW'(1);
			col_count_q <= DimW'(1);
			scan_mode_q <= ModeW'(MODE_RASTER);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: row_count_q <= cfg_data[DimW-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[DimW-1:0];
				REG_SCAN_MODE: scan_mode_q <= cfg_data[ModeW-1:0];
				default: begin
				end
			endcase
		end
	end

	msog_walk u_walk (
		.state      (state_q),
		.row_count  (row_count_q),
		.col_count  (col_count_q),
		.scan_mode  (scan_mode_q),
		.restart    (restart),
		.next_state (next_state),
		.result     (step_result)
	);

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_free = !main_valid_q || !out_stall;

	// Walker position; a write to an index with no register leaves it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_write && (cfg_index <= REG_SCAN_MODE)) begin
			state_q.active <= 1'b0;
		end else if (in_fire) begin
			state_q <= next_state;
		end
	end

	// Valid flags of the output register and its skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			main_valid_q <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (in_fire) begin
				main_q <= step_result;
			end
		end else if (in_fire) begin
			skid_q <= step_result;
		end
	end

	assign out_valid  = main_valid_q;
	assign row_index  = main_q.row_index;
	assign col_index  = main_q.col_index;
	assign seq_value  = main_q.seq_value;
	assign last_cell  = main_q.last_cell;
	assign size_error = main_q.size_error;

endmodule

FILE: rtl/msog_walk.sv
// Next-cell logic of the matrix scan order generator: one step of the walk.
// Purely combinational; depends on msog_pkg.
module msog_walk (
	input  msog_pkg::walk_state_t        state,
	input  logic [msog_pkg::DimW-1:0]    row_count,
	input  logic [msog_pkg::DimW-1:0]    col_count,
	input  logic [msog_pkg::ModeW-1:0]   scan_mode,
	input  logic                         restart,
	output msog_pkg::walk_state_t        next_state,
	output msog_pkg::walk_result_t       result
);
	import msog_pkg::*;

	scan_mode_t      mode;
	walk_state_t     cur;
	logic            size_bad;
	logic            more;
	logic            row_inc_ok;
	logic            col_inc_ok;
	logic            diag_lt_rows;
	logic            diag_lt_cols;
	logic [DimW-1:0] rows_m1;
	logic [DimW-1:0] cols_m1;

	// Out-of-range mode codes fall back to the raster order.
	always_comb begin
		if (scan_mode > ModeW'(MODE_COL_SNAKE)) begin
			mode = MODE_RASTER;
		end else begin
			mode = scan_mode_t'(scan_mode);
		end
	end

	assign size_bad = (row_count == '0) || ({2'b00, row_count} > MaxRowsW) ||
	                  (col_count == '0) || ({2'b00, col_count} > MaxColsW);
	assign rows_m1  = row_count - DimW'(1);
	assign cols_m1  = col_count - DimW'(1);

	// Cell to emit: the stored position, or the first cell of a fresh scan.
	always_comb begin
		cur = state;
		if (restart || !state.active) begin
			cur.count  = '0;
			cur.second = 1'b0;
			cur.row    = '0;
			cur.col    = '0;
			cur.diag   = '0;
			unique case (mode)
				MODE_DIAG_DR: begin
					cur.col  = cols_m1;
					cur.diag = cols_m1;
				end
				MODE_DIAG_UL, MODE_ROW_SNAKE: begin
					cur.row = rows_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// Bounds checks on the emitted cell and the diagonal start.
	assign row_inc_ok   = ({1'b0, cur.row} + (DimW + 1)'(1)) < {1'b0, row_count};
	assign col_inc_ok   = ({1'b0, cur.col} + (DimW + 1)'(1)) < {1'b0, col_count};
	assign diag_lt_rows = ({1'b0, cur.diag} + (DimW + 1)'(1)) < {1'b0, row_count};
	assign diag_lt_cols = ({1'b0, cur.diag} + (DimW + 1)'(1)) < {1'b0, col_count};

	// Move to the following cell in the selected order.
	always_comb begin
		next_state       = cur;
		next_state.count = cur.count + SeqW'(1);
		more             = 1'b0;
		unique case (mode)
			MODE_DIAG_DR: begin
				if (row_inc_ok && col_inc_ok) begin
					next_state.row = cur.row + DimW'(1);
					next_state.col = cur.col + DimW'(1);
					more           = 1'b1;
				end else if (!cur.second) begin
					if (cur.diag != '0) begin
						next_state.diag = cur.diag - DimW'(1);
						next_state.row  = '0;
						next_state.col  = cur.diag - DimW'(1);
						more            = 1'b1;
					end else if (row_count > DimW'(1)) begin
						next_state.second = 1'b1;
						next_state.diag   = DimW'(1);
						next_state.row    = DimW'(1);
						next_state.col    = '0;
						more              = 1'b1;
					end
				end else if (diag_lt_rows) begin
					next_state.diag = cur.diag + DimW'(1);
					next_state.row  = cur.diag + DimW'(1);
					next_state.col  = '0;
					more            = 1'b1;
				end
			end
			MODE_DIAG_UL: begin
				if ((cur.row != '0) && (cur.col != '0)) begin
					next_state.row = cur.row - DimW'(1);
					next_state.col = cur.col - DimW'(1);
					more           = 1'b1;
				end else if (!cur.second) begin
					if (diag_lt_cols) begin
						next_state.diag = cur.diag + DimW'(1);
						next_state.row  = rows_m1;
						next_state.col  = cur.diag + DimW'(1);
						more            = 1'b1;
					end else if (row_count >= DimW'(2)) begin
						next_state.second = 1'b1;
						next_state.diag   = row_count - DimW'(2);
						next_state.row    = row_count - DimW'(2);
						next_state.col    = cols_m1;
						more              = 1'b1;
					end
				end else if (cur.diag != '0) begin
					next_state.diag = cur.diag - DimW'(1);
					next_state.row  = cur.diag - DimW'(1);
					next_state.col  = cols_m1;
					more            = 1'b1;
				end
			end
			MODE_ROW_SNAKE: begin
				// Rows an even distance above the bottom run left to right.
				if ((row_count[0] ^ cur.row[0]) && col_inc_ok) begin
					next_state.col = cur.col + DimW'(1);
					more           = 1'b1;
				end else if (!(row_count[0] ^ cur.row[0]) && (cur.col != '0)) begin
					next_state.col = cur.col - DimW'(1);
					more           = 1'b1;
				end else if (cur.row != '0) begin
					next_state.row = cur.row - DimW'(1);
					more           = 1'b1;
				end
			end
			MODE_COL_SNAKE: begin
				// Even columns run downwards, odd columns upwards.
				if (!cur.col[0] && row_inc_ok) begin
					next_state.row = cur.row + DimW'(1);
					more           = 1'b1;
				end else if (cur.col[0] && (cur.row != '0)) begin
					next_state.row = cur.row - DimW'(1);
					more           = 1'b1;
				end else if (col_inc_ok) begin
					next_state.col = cur.col + DimW'(1);
					more           = 1'b1;
				end
			end
			default: begin
				if (col_inc_ok) begin
					next_state.col = cur.col + DimW'(1);
					more           = 1'b1;
				end else if (row_inc_ok) begin
					next_state.row = cur.row + DimW'(1);
					next_state.col = '0;
					more           = 1'b1;
				end
			end
		endcase
		next_state.active = more;

		result.row_index  = cur.row[IdxW-1:0];
		result.col_index  = cur.col[IdxW-1:0];
		result.seq_value  = next_state.count;
		result.last_cell  = !more;
		result.size_error = 1'b0;

		// An illegal size gives an error result and leaves the walker idle.
		if (size_bad) begin
			next_state        = state;
			next_state.active = 1'b0;
			result            = '0;
			result.size_error = 1'b1;
		end
	end

endmodule

FILE: rtl/msog_checker.sv
// Port-level checks for matrix_scan_order_generator, attached by a bind statement.
// Depends on msog_pkg and on the top level's port names.
module msog_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [msog_pkg::IdxW-1:0]     row_index,
	input logic [msog_pkg::IdxW-1:0]     col_index,
	input logic [msog_pkg::SeqW-1:0]     seq_value,
	input logic                          last_cell,
	input logic                          size_error
);
	import msog_pkg::*;

	// With nothing held at the output the block must take a transaction.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while no result is held");

	// A transaction taken into an empty output shows up on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> out_valid)
		else $error("accepted transaction produced no result");

	// An error result carries no cell.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && size_error) |->
		(row_index == '0) && (col_index == '0) && (seq_value == '0) && !last_cell)
		else $error("size error result carries cell data");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(row_index) &&
		$stable(col_index) && $stable(seq_value) && $stable(last_cell) &&
		$stable(size_error))
		else $error("stalled result changed");

endmodule

bind matrix_scan_order_generator msog_checker u_msog_checker (.*);
